>>> rtl/hue_luma_color_likeness_top_macros.svh
// Assertion macros for the hue and luma likeness block.
// Used by hue_luma_color_likeness_top.sv; the including scope provides clk and rst.
`ifndef HUE_LUMA_COLOR_LIKENESS_TOP_MACROS_SVH
`define HUE_LUMA_COLOR_LIKENESS_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HLCL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("likeness pipeline check failed");

// Next-cycle implication, disabled during reset.
`define HLCL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("likeness pipeline check failed");

`endif

>>> rtl/hlcl_pkg.sv
// Package for the hue and luma likeness block: payload types, constants and
// the per-step helpers of the hue and likeness dividers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hlcl_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [8:0] likeness;
    logic       ideal_ok;
  } like_t;

  // Hue sector division in flight: rem / den gives the rounded part.
  typedef struct packed {
    logic [20:0] rem;
    logic [8:0]  den;
    logic [11:0] quo;
    logic [14:0] base;
    logic        neg;
    logic        grey;
  } hue_div_t;

  // Final division: rem / (256 * den).
  typedef struct packed {
    logic [34:0] rem;
    logic [17:0] den;
    logic [8:0]  quo;
    logic        ok;
  } like_div_t;

  // Hue angles in 1/64 degree.
  localparam logic [14:0] HUE_FULL  = 15'd23040;
  localparam logic [14:0] HUE_HALF  = 15'd11520;
  localparam logic [14:0] HUE_CLAMP = 15'd5760;
  localparam logic [14:0] HUE_GREEN = 15'd7680;
  localparam logic [14:0] HUE_BLUE  = 15'd15360;
  localparam logic [14:0] TAN_SPAN  = 15'd2048;
  localparam logic [12:0] HUE_SIXTH = 13'd7680;

  localparam logic [17:0] LUMA_MIN_OK = 18'd40000;
  localparam logic [8:0]  LIKE_MAX    = 9'd256;

  // Tangent table construction, Q30 radians.
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint          ONE_Q30 = 64'sd1073741824;
  localparam longint unsigned ONE_Q16 = 64'd65536;

  function automatic logic [17:0] luma1000(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
    return 18'(r) * 18'd299 + 18'(g) * 18'd587 + 18'(b) * 18'd114;
  endfunction

  // Sets up the hue division for one color: sector base, sign and operands.
  function automatic hue_div_t hue_prep(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
    logic [7:0] mx;
    logic [7:0] mn;
    logic [7:0] d;
    logic [7:0] n;
    hue_div_t   o;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    o.grey = (d == 8'd0);
    o.den  = (d == 8'd0) ? 9'd2 : {d, 1'b0};
    o.quo  = '0;
    if (r == mx) begin
      o.neg  = (g < b);
      o.base = (g < b) ? HUE_FULL : 15'd0;
      n      = (g < b) ? b - g : g - b;
    end else if (g == mx) begin
      o.neg  = (b < r);
      o.base = HUE_GREEN;
      n      = (b < r) ? r - b : b - r;
    end else begin
      o.neg  = (r < g);
      o.base = HUE_BLUE;
      n      = (r < g) ? g - r : r - g;
    end
    o.rem = 21'(n) * 21'(HUE_SIXTH) + 21'(d);
    return o;
  endfunction

  // One restoring-division step for quotient bit pos.
  function automatic hue_div_t hue_step(input hue_div_t a, input logic [3:0] pos);
    logic [20:0] sd;
    hue_div_t    o;
    o  = a;
    sd = 21'(a.den) << pos;
    if (a.rem >= sd) begin
      o.rem      = a.rem - sd;
      o.quo[pos] = 1'b1;
    end
    return o;
  endfunction

  function automatic like_div_t like_step(input like_div_t a, input logic [3:0] pos);
    logic [34:0] sd;
    like_div_t   o;
    o  = a;
    sd = 35'(a.den) << ({1'b0, pos} + 5'd8);
    if (a.rem >= sd) begin
      o.rem      = a.rem - sd;
      o.quo[pos] = 1'b1;
    end
    return o;
  endfunction

endpackage

`default_nettype wire

>>> rtl/hue_luma_color_likeness_top.sv
// Top level of the hue and luma likeness block: an eleven-stage pipeline.
// Depends on hlcl_pkg and hue_luma_color_likeness_top_macros.svh.
//
//   Channel  Direction  Handshake               Payload
//   pix      in         pix_valid / pix_stall   hlcl_pkg::pix_t (red, green, blue)
//   like     out        like_valid / like_stall hlcl_pkg::like_t (likeness, ideal_ok)
//   cfg      in         cfg_write_en            cfg_index, cfg_data
//
// One pixel enters per cycle unless stalled, and its result leaves the last stage;
// unstalled, the pipeline sets the rate, one transfer per clock in each direction.
// The two hue divisions take three stages at four quotient bits each, and
// the final luma-ratio division takes three stages at three bits each.
// Reset (rst, synchronous) clears the valid bits and the ideal color.
// A stall on the output freezes every stage together, so nothing is lost or
// repeated; the input is stalled only while a finished result waits.
`timescale 1ns / 1ps
`default_nettype none

`include "hue_luma_color_likeness_top_macros.svh"

module hue_luma_color_likeness_top #(
  parameter int TAN_TABLE_ENTRIES = 256
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            pix_valid,
  output logic                 pix_stall,
  input  wire hlcl_pkg::pix_t  pix,
  output logic                 like_valid,
  input  wire logic            like_stall,
  output hlcl_pkg::like_t      like,
  input  wire logic            cfg_write_en,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [7:0]      cfg_data
);

  localparam int IdxW  = $clog2(TAN_TABLE_ENTRIES + 1);
  localparam int ProdW = IdxW + 12;

  // Register indexes of the configuration port.
  localparam logic [1:0] RegRed   = 2'd0;
  localparam logic [1:0] RegGreen = 2'd1;
  localparam logic [1:0] RegBlue  = 2'd2;

  // Tangent table construction constants.
  localparam longint unsigned TanDen  = 64'd11520 * longint'(TAN_TABLE_ENTRIES);
  localparam longint unsigned TanSpan = 64'd2048;

  logic [7:0] ideal_red;
  logic [7:0] ideal_green;
  logic [7:0] ideal_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      ideal_red   <= '0;
      ideal_green <= '0;
      ideal_blue  <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        RegRed:   ideal_red   <= cfg_data;
        RegGreen: ideal_green <= cfg_data;
        RegBlue:  ideal_blue  <= cfg_data;
        default:  ;
      endcase
    end
  end

  // Hue score table: 65536 - 2*tan, floored at zero, built at elaboration.
  logic [16:0] score_rom [0:TAN_TABLE_ENTRIES];

  genvar k;
  generate
    for (k = 0; k <= TAN_TABLE_ENTRIES; k++) begin : g_tan
      localparam longint unsigned XU =
        (longint'(k) * TanSpan * hlcl_pkg::PI_Q30 + TanDen / 2) / TanDen;
      localparam longint X  = longint'(XU);
      localparam longint X2 = (X * X) >>> 30;
      localparam longint X3 = (X2 * X) >>> 30;
      localparam longint X4 = (X2 * X2) >>> 30;
      localparam longint X5 = (X4 * X) >>> 30;
      localparam longint X6 = (X4 * X2) >>> 30;
      localparam longint X7 = (X6 * X) >>> 30;
      localparam longint X8 = (X4 * X4) >>> 30;
      localparam longint X9 = (X8 * X) >>> 30;
      localparam longint S  = X - X3 / 6 + X5 / 120 - X7 / 5040 + X9 / 362880;
      localparam longint C  = hlcl_pkg::ONE_Q30 - X2 / 2 + X4 / 24 - X6 / 720 + X8 / 40320;
      localparam longint unsigned SU = longint'(S);
      localparam longint unsigned CU = longint'(C);
      localparam longint unsigned T  = ((SU << 16) + CU / 2) / CU;
      localparam longint unsigned T2 = 2 * T;
      localparam longint unsigned SC = (T2 < hlcl_pkg::ONE_Q16) ? hlcl_pkg::ONE_Q16 - T2 : 0;
      assign score_rom[k] = 17'(SC);
    end
  endgenerate

  // Global advance: every stage moves unless a finished result is held.
  logic adv;
  assign adv       = !(like_valid && like_stall);
  assign pix_stall = !adv;

  logic v [1:10];

  // Stages 1 to 4: hue divisions for the pixel and the ideal color.
  hlcl_pkg::hue_div_t hdp [1:4];
  hlcl_pkg::hue_div_t hdi [1:4];
  hlcl_pkg::hue_div_t hdp_next [2:4];
  hlcl_pkg::hue_div_t hdi_next [2:4];
  logic [17:0] yp [1:5];
  logic [17:0] yi [1:5];
  logic        ok [1:6];

  logic [17:0] yi_now;
  assign yi_now = hlcl_pkg::luma1000(ideal_red, ideal_green, ideal_blue);

  always_comb begin
    for (int j = 2; j <= 4; j++) begin
      hdp_next[j] = hdp[j-1];
      hdi_next[j] = hdi[j-1];
      for (int s = 0; s < 4; s++) begin
        hdp_next[j] = hlcl_pkg::hue_step(hdp_next[j], 4'(11 - 4 * (j - 2) - s));
        hdi_next[j] = hlcl_pkg::hue_step(hdi_next[j], 4'(11 - 4 * (j - 2) - s));
      end
    end
  end

  // Stage 5: hue distance and table index.
  logic [14:0] hue_p;
  logic [14:0] hue_i;
  logic [14:0] dist_raw;
  logic [14:0] dist_wrap;
  logic [14:0] hue_dist;
  logic [ProdW-1:0] idx_full;
  logic [IdxW-1:0]  idx_next;
  logic [IdxW-1:0]  idx5;
  logic             span5;

  always_comb begin
    hue_p = hdp[4].grey ? 15'd0 :
            (hdp[4].neg ? hdp[4].base - 15'(hdp[4].quo) : hdp[4].base + 15'(hdp[4].quo));
    hue_i = hdi[4].grey ? 15'd0 :
            (hdi[4].neg ? hdi[4].base - 15'(hdi[4].quo) : hdi[4].base + 15'(hdi[4].quo));
    dist_raw  = (hue_p > hue_i) ? hue_p - hue_i : hue_i - hue_p;
    dist_wrap = (dist_raw > hlcl_pkg::HUE_HALF) ? hlcl_pkg::HUE_FULL - dist_raw : dist_raw;
    hue_dist  = (dist_wrap > hlcl_pkg::HUE_CLAMP) ? hlcl_pkg::HUE_CLAMP : dist_wrap;
    idx_full  = (ProdW'(hue_dist[10:0]) * ProdW'(TAN_TABLE_ENTRIES) + ProdW'(1024)) >> 11;
    idx_next  = (idx_full > ProdW'(TAN_TABLE_ENTRIES)) ? IdxW'(TAN_TABLE_ENTRIES)
                                                        : IdxW'(idx_full);
  end

  // Stage 6: score lookup and luma ordering.
  logic [16:0] score6;
  logic [17:0] ymin6;
  logic [17:0] ymax6;

  // Stages 7 to 10: likeness division.
  hlcl_pkg::like_div_t ld [7:10];
  hlcl_pkg::like_div_t ld_next [8:10];

  always_comb begin
    for (int j = 8; j <= 10; j++) begin
      ld_next[j] = ld[j-1];
      for (int s = 0; s < 3; s++) begin
        ld_next[j] = hlcl_pkg::like_step(ld_next[j], 4'(8 - 3 * (j - 8) - s));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 1; j <= 10; j++) v[j] <= 1'b0;
      like_valid <= 1'b0;
    end else if (adv) begin
      v[1] <= pix_valid;
      for (int j = 2; j <= 10; j++) v[j] <= v[j-1];
      like_valid <= v[10];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hdp[1] <= hlcl_pkg::hue_prep(pix.red, pix.green, pix.blue);
      hdi[1] <= hlcl_pkg::hue_prep(ideal_red, ideal_green, ideal_blue);
      yp[1]  <= hlcl_pkg::luma1000(pix.red, pix.green, pix.blue);
      yi[1]  <= yi_now;
      ok[1]  <= (yi_now >= hlcl_pkg::LUMA_MIN_OK);
      for (int j = 2; j <= 4; j++) begin
        hdp[j] <= hdp_next[j];
        hdi[j] <= hdi_next[j];
      end
      for (int j = 2; j <= 5; j++) begin
        yp[j] <= yp[j-1];
        yi[j] <= yi[j-1];
      end
      for (int j = 2; j <= 6; j++) ok[j] <= ok[j-1];

      idx5  <= idx_next;
      span5 <= (hue_dist < hlcl_pkg::TAN_SPAN);

      score6 <= span5 ? score_rom[idx5] : 17'd0;
      ymin6  <= (yp[5] < yi[5]) ? yp[5] : yi[5];
      ymax6  <= (yp[5] < yi[5]) ? yi[5] : yp[5];

      ld[7].rem <= 35'(score6) * 35'(ymin6) + (35'(ymax6) << 7);
      ld[7].den <= ymax6;
      ld[7].quo <= '0;
      ld[7].ok  <= ok[6];
      for (int j = 8; j <= 10; j++) ld[j] <= ld_next[j];

      like.ideal_ok <= ld[10].ok;
      like.likeness <= !ld[10].ok ? 9'd0 :
                       ((ld[10].quo > hlcl_pkg::LIKE_MAX) ? hlcl_pkg::LIKE_MAX : ld[10].quo);
    end
  end

  // A dark ideal color always reports a zero likeness.
  `HLCL_ASSERT_NOW(a_dark_zero, like_valid && !like.ideal_ok, like.likeness == 9'd0)
  // The score never exceeds one in 1/256 units.
  `HLCL_ASSERT_NOW(a_like_max, like_valid, like.likeness <= hlcl_pkg::LIKE_MAX)
  // An accepted pixel always occupies the first stage next cycle.
  `HLCL_ASSERT_NEXT(a_take_enters, pix_valid && !pix_stall, v[1])

endmodule

`default_nettype wire

>>> tb/sv/hue_luma_color_likeness_top_test.sv
// Testbench for hue_luma_color_likeness_top: directed and random pixels, each result checked
// against a typed value or a predictor of the hue distance, tangent score and luma ratio.
// Depends on hlcl_pkg and the RTL of the block.
`timescale 1ns / 1ps

module hue_luma_color_likeness_top_test;

  localparam int TAN_ENTRIES = 256;
  localparam int TAN_WIDTH = 2048;
  localparam int STALL_LIMIT = 20000;
  localparam int PIPE_DEPTH = 11;

  // Register indexes of the ideal color.
  typedef enum logic [1:0] {
    REG_IDEAL_RED = 2'd0,
    REG_IDEAL_GREEN = 2'd1,
    REG_IDEAL_BLUE = 2'd2,
    REG_UNUSED = 2'd3
  } reg_index_t;

  logic clk;
  logic rst;
  logic pix_valid;
  logic pix_stall;
  hlcl_pkg::pix_t pix;
  logic like_valid;
  logic like_stall;
  hlcl_pkg::like_t like;
  logic cfg_write_en;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  hue_luma_color_likeness_top uut (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
    .like_valid(like_valid), .like_stall(like_stall), .like(like),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // The predictor keeps its own copy of the ideal color and its own tangent table.
  longint unsigned tan_q16[TAN_ENTRIES + 1];
  logic [7:0] ideal_r, ideal_g, ideal_b;
  hlcl_pkg::like_t expected_likeness[$];
  int failures = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Builds the tangent table with Taylor series in Q30 radians.
  task automatic build_tangents();
    longint unsigned den, q;
    longint x, x2, x3, x4, x5, x6, x7, x8, x9, s, c;
    den = 64'd180 * 64'd64 * TAN_ENTRIES;
    for (int k = 0; k <= TAN_ENTRIES; k++) begin
      q = (longint'(k) * TAN_WIDTH * hlcl_pkg::PI_Q30 + den / 2) / den;
      x = longint'(q);
      x2 = (x * x) >>> 30;
      x3 = (x2 * x) >>> 30;
      x4 = (x2 * x2) >>> 30;
      x5 = (x4 * x) >>> 30;
      x6 = (x4 * x2) >>> 30;
      x7 = (x6 * x) >>> 30;
      x8 = (x4 * x4) >>> 30;
      x9 = (x8 * x) >>> 30;
      s = x - x3 / 6 + x5 / 120 - x7 / 5040 + x9 / 362880;
      c = hlcl_pkg::ONE_Q30 - x2 / 2 + x4 / 24 - x6 / 720 + x8 / 40320;
      tan_q16[k] = ((unsigned'(s) << 16) + unsigned'(c) / 2) / unsigned'(c);
    end
  endtask

  // Hue in 1/64 degree; a grey color has hue zero.
  function automatic int unsigned hue_of(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    int unsigned mx, mn, d;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    if (d == 0) return 0;
    if (r == mx)
      return (g >= b) ? (7680 * (g - b) + d) / (2 * d)
                      : 23040 - (7680 * (b - g) + d) / (2 * d);
    if (g == mx)
      return (b >= r) ? 7680 + (7680 * (b - r) + d) / (2 * d)
                      : 7680 - (7680 * (r - b) + d) / (2 * d);
    return (r >= g) ? 15360 + (7680 * (r - g) + d) / (2 * d)
                    : 15360 - (7680 * (g - r) + d) / (2 * d);
  endfunction

  function automatic hlcl_pkg::like_t predict_likeness(input hlcl_pkg::pix_t p);
    longint unsigned yi, yp, ymin, ymax, score, idx, t2, lk;
    int unsigned h1, h2, hue_dist;
    hlcl_pkg::like_t o;
    yi = 299 * ideal_r + 587 * ideal_g + 114 * ideal_b;
    if (yi < 40000) begin
      o.likeness = '0;
      o.ideal_ok = 1'b0;
      return o;
    end
    h1 = hue_of(ideal_r, ideal_g, ideal_b);
    h2 = hue_of(p.red, p.green, p.blue);
    hue_dist = (h1 > h2) ? h1 - h2 : h2 - h1;
    if (hue_dist > 11520) hue_dist = 23040 - hue_dist;
    if (hue_dist > 5760) hue_dist = 5760;
    score = 0;
    if (hue_dist < TAN_WIDTH) begin
      idx = (longint'(hue_dist) * TAN_ENTRIES + TAN_WIDTH / 2) / TAN_WIDTH;
      if (idx > TAN_ENTRIES) idx = TAN_ENTRIES;
      t2 = 2 * tan_q16[idx];
      score = (t2 < 65536) ? 65536 - t2 : 0;
    end
    yp = 299 * p.red + 587 * p.green + 114 * p.blue;
    ymin = (yp < yi) ? yp : yi;
    ymax = (yp < yi) ? yi : yp;
    lk = (2 * score * ymin + 256 * ymax) / (512 * ymax);
    if (lk > 256) lk = 256;
    o.likeness = lk[8:0];
    o.ideal_ok = 1'b1;
    return o;
  endfunction

  // Writes one register of the ideal color; only called while the pipeline is empty.
  // The caller drops the write enable once its last write is done.
  task automatic write_reg(input reg_index_t idx, input logic [7:0] val);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    case (idx)
      REG_IDEAL_RED: ideal_r = val;
      REG_IDEAL_GREEN: ideal_g = val;
      REG_IDEAL_BLUE: ideal_b = val;
      default: ;
    endcase
  endtask

  task automatic set_ideal(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    write_reg(REG_IDEAL_RED, r);
    write_reg(REG_IDEAL_GREEN, g);
    write_reg(REG_IDEAL_BLUE, b);
    cfg_write_en <= 1'b0;
  endtask

  // Stops offering pixels and waits until every expected result has arrived.
  task automatic wait_results();
    pix_valid <= 1'b0;
    while (expected_likeness.size() != 0) @(negedge clk);
  endtask

  // Waits until every expected result has arrived and the pipeline has drained.
  task automatic drain_pipeline();
    wait_results();
    repeat (PIPE_DEPTH + 2) @(negedge clk);
  endtask

  // Offers one pixel, honoring the sender idle rate, and holds it until the transfer.
  task automatic send_pixel(input hlcl_pkg::pix_t p, input hlcl_pkg::like_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_valid <= 1'b0;
      @(negedge clk);
    end
    pix_valid <= 1'b1;
    pix <= p;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    expected_likeness.push_back(want);
    @(negedge clk);
  endtask

  // Random pixels: half near the ideal color so the score is often nonzero.
  function automatic hlcl_pkg::pix_t random_pixel();
    hlcl_pkg::pix_t p;
    int unsigned mode;
    mode = $urandom_range(9);
    if (mode < 5) begin
      p.red = 8'(int'(ideal_r) + int'($urandom_range(40)) - 20);
      p.green = 8'(int'(ideal_g) + int'($urandom_range(40)) - 20);
      p.blue = 8'(int'(ideal_b) + int'($urandom_range(40)) - 20);
    end else if (mode == 5) begin
      p.red = 8'($urandom_range(255));
      p.green = p.red;
      p.blue = p.red;
    end else begin
      p = hlcl_pkg::pix_t'(24'($urandom));
    end
    return p;
  endfunction

  // Directed rows; the expected value is typed only where it is obvious.
  typedef struct {
    logic [7:0] ir, ig, ib;
    hlcl_pkg::pix_t p;
    logic known;
    hlcl_pkg::like_t want;
  } row_t;

  row_t rows[$];

  function automatic row_t mk(input logic [7:0] ir, input logic [7:0] ig,
                              input logic [7:0] ib, input logic [7:0] r,
                              input logic [7:0] g, input logic [7:0] b,
                              input logic known, input logic [8:0] lk,
                              input logic ok);
    row_t t;
    t.ir = ir; t.ig = ig; t.ib = ib;
    t.p = '{red: r, green: g, blue: b};
    t.known = known;
    t.want = '{likeness: lk, ideal_ok: ok};
    return t;
  endfunction

  initial begin
    rows.push_back(mk(0, 0, 0, 255, 255, 255, 1, 0, 0));        // ideal too dark after reset
    rows.push_back(mk(0, 0, 0, 0, 0, 0, 1, 0, 0));
    rows.push_back(mk(255, 255, 255, 255, 255, 255, 1, 256, 1)); // grey matches grey exactly
    rows.push_back(mk(255, 255, 255, 0, 0, 0, 0, 0, 0));         // black pixel against white
    rows.push_back(mk(255, 255, 255, 128, 128, 128, 0, 0, 0));
    rows.push_back(mk(255, 0, 0, 255, 0, 0, 1, 256, 1));         // identical pure red
    rows.push_back(mk(255, 0, 0, 0, 255, 0, 1, 0, 1));           // hue too far away
    rows.push_back(mk(255, 0, 0, 0, 0, 255, 1, 0, 1));
    rows.push_back(mk(255, 0, 0, 255, 0, 10, 0, 0, 0));          // red across hue wrap
    rows.push_back(mk(255, 0, 0, 255, 10, 0, 0, 0, 0));
    rows.push_back(mk(0, 255, 0, 0, 255, 0, 1, 256, 1));
    rows.push_back(mk(0, 255, 0, 10, 255, 0, 0, 0, 0));
    rows.push_back(mk(0, 255, 0, 0, 255, 10, 0, 0, 0));
    rows.push_back(mk(0, 0, 255, 0, 0, 255, 1, 0, 0));           // pure blue ideal is too dark
    rows.push_back(mk(0, 0, 255, 10, 0, 255, 0, 0, 0));
    rows.push_back(mk(0, 0, 255, 0, 10, 255, 0, 0, 0));
    rows.push_back(mk(133, 0, 0, 133, 0, 0, 0, 0, 0));           // luma right at the limit
    rows.push_back(mk(134, 0, 0, 134, 0, 0, 1, 256, 1));
    rows.push_back(mk(200, 100, 50, 100, 50, 25, 0, 0, 0));      // same hue, half luma
    rows.push_back(mk(200, 100, 50, 170, 100, 50, 0, 0, 0));
  end

  // Watchdog: counts cycles in which no transfer happens on either channel.
  always @(posedge clk) begin
    if ((pix_valid && !pix_stall) || (like_valid && !like_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("** hue_luma_color_likeness_top: FAILED **");
      $finish;
    end
  end

  // Receiver stall changes on the falling edge at the current idle rate.
  always @(negedge clk) begin
    if (rst) like_stall <= 1'b0;
    else like_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Each result transfer is compared with the oldest pending expectation.
  always @(posedge clk) begin
    hlcl_pkg::like_t want;
    if (!rst && like_valid && !like_stall) begin
      if (expected_likeness.size() == 0) begin
        $display("%0t: unexpected result likeness=%0d ideal_ok=%0b",
                 $time, like.likeness, like.ideal_ok);
        failures++;
      end else begin
        want = expected_likeness.pop_front();
        if (like.likeness !== want.likeness) begin
          $display("%0t: likeness expected %0d actual %0d", $time, want.likeness,
                   like.likeness);
          failures++;
        end
        if (like.ideal_ok !== want.ideal_ok) begin
          $display("%0t: ideal_ok expected %0b actual %0b", $time, want.ideal_ok,
                   like.ideal_ok);
          failures++;
        end
      end
    end
  end

  initial begin
    hlcl_pkg::like_t want;
    hlcl_pkg::pix_t p;
    build_tangents();
    ideal_r = '0;
    ideal_g = '0;
    ideal_b = '0;
    rst = 1'b1;
    pix_valid = 1'b0;
    pix = '0;
    cfg_write_en = 1'b0;
    cfg_index = REG_IDEAL_RED;
    cfg_data = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table; the first rows run against the ideal color left by reset.
    foreach (rows[i]) begin
      if (i >= 2 && (rows[i].ir != ideal_r || rows[i].ig != ideal_g ||
                     rows[i].ib != ideal_b)) begin
        drain_pipeline();
        set_ideal(rows[i].ir, rows[i].ig, rows[i].ib);
      end
      want = rows[i].known ? rows[i].want : predict_likeness(rows[i].p);
      send_pixel(rows[i].p, want);
    end
    // The unused register index must leave the ideal color alone.
    drain_pipeline();
    write_reg(REG_UNUSED, 8'hff);
    cfg_write_en <= 1'b0;
    p = '{red: 8'd200, green: 8'd100, blue: 8'd50};
    send_pixel(p, predict_likeness(p));

    // Random phases, with a new ideal color every 100 pixels.
    for (int phase = 0; phase < 8; phase++) begin
      send_idle_pct = (phase < 3) ? 15 : (phase < 6) ? 87 : 0;
      recv_idle_pct = (phase < 3) ? 87 : (phase < 6) ? 15 : 0;
      drain_pipeline();
      case (phase)
        0: set_ideal(8'd255, 8'd255, 8'd0);
        1: set_ideal(8'd0, 8'd0, 8'd0);
        2: set_ideal(8'd0, 8'd255, 8'd255);
        default: set_ideal(8'($urandom_range(255)), 8'($urandom_range(255)),
                           8'($urandom_range(255)));
      endcase
      for (int n = 0; n < 100; n++) begin
        // Once per phase the sender holds off until the pipeline is empty.
        if (n == 50) wait_results();
        p = random_pixel();
        send_pixel(p, predict_likeness(p));
      end
    end

    wait_results();
    repeat (PIPE_DEPTH * 4) @(negedge clk);
    if (failures == 0) $display("** hue_luma_color_likeness_top: PASSED **");
    else $display("** hue_luma_color_likeness_top: FAILED **");
    $finish;
  end

endmodule

>>> hue_luma_color_likeness_top.f
+incdir+rtl
rtl/hlcl_pkg.sv
rtl/hue_luma_color_likeness_top.sv
tb/sv/hue_luma_color_likeness_top_test.sv
